>>> rtl/wfp_pkg.sv
`timescale 1ns / 1ps

package wfp_pkg;

    localparam int HASH_W = 34;
    localparam logic [HASH_W-1:0] HASH_MOD = 34'd10000000000;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 34;
    localparam logic [CFG_IDX_W-1:0] REG_KGRAM_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_WEIGHT = 2'd2;

    localparam logic [6:0] KGRAM_RESET = 7'd5;
    localparam logic [6:0] WINDOW_RESET = 7'd4;
    localparam logic [HASH_W-1:0] WEIGHT_RESET = 34'd81;

    localparam int DEF_MAX_KGRAM = 64;
    localparam int DEF_MAX_WINDOW = 64;

    // controller -> datapath
    typedef struct packed {
        logic take;
        logic rd_oldest;
        logic mul_start;
        logic mul_step;
        logic fix;
        logic hash_upd;
        logic win_upd;
        logic scan_start;
        logic scan_step;
        logic out_load;
    } wfp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic kgram_full;
        logic rescan;
        logic emit;
        logic scan_done;
        logic min_nz;
    } wfp_sts_t;

endpackage

>>> rtl/winnowing_fingerprint.sv
`timescale 1ns / 1ps

// Winnowing fingerprint selector. Bytes of a file enter one word at a time;
// a base-3 Karp-Rabin hash over the last kgram_length bytes is kept modulo
// 10^10, and the last window_width hashes are winnowed: the window minimum
// (rightmost on ties) is sent out when the window first fills, when a new
// hash is at or below the held minimum, and after every rescan that follows
// the held minimum sliding out. A zero minimum is never sent. Set new_file on
// the first byte of each file to clear all history. top_weight must hold
// 3^(kgram_length-1) mod 10^10. The user must write configuration only
// while idle; the block does not enforce this. A byte that only fills the
// first k-gram is taken, checked and hashed; a rolling byte first reads the
// leaving byte and multiplies it with top_weight by shift-and-add, one bit
// per cycle. Each hash then updates the window, and a rescan reads the hash
// window memory one entry per cycle. The output step waits for any previous
// word to leave. The next byte is taken while a result still waits in the
// output register.

module winnowing_fingerprint #(
    parameter int MAX_KGRAM = wfp_pkg::DEF_MAX_KGRAM,
    parameter int MAX_WINDOW = wfp_pkg::DEF_MAX_WINDOW
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [wfp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wfp_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [7:0]                     s_byte_value,
    input  logic                           s_new_file,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [wfp_pkg::HASH_W-1:0]     m_fingerprint_hash
);

    wfp_pkg::wfp_cmd_t cmd;
    wfp_pkg::wfp_sts_t sts;

    // sequencing: which step of the hash / window update runs this cycle
    wfp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    // hash arithmetic, byte and hash rings, minimum tracking, output word
    wfp_datapath #(
        .MAX_KGRAM  (MAX_KGRAM),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_byte_value (s_byte_value),
        .s_new_file   (s_new_file),
        .cmd          (cmd),
        .sts          (sts),
        .out_hash     (m_fingerprint_hash)
    );

endmodule

>>> rtl/wfp_ram.sv
`timescale 1ns / 1ps

module wfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/wfp_datapath.sv
`timescale 1ns / 1ps

module wfp_datapath #(
    parameter int MAX_KGRAM = wfp_pkg::DEF_MAX_KGRAM,
    parameter int MAX_WINDOW = wfp_pkg::DEF_MAX_WINDOW
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [wfp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [wfp_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  logic [7:0]                    s_byte_value,
    input  logic                          s_new_file,
    input  wfp_pkg::wfp_cmd_t             cmd,
    output wfp_pkg::wfp_sts_t             sts,
    output logic [wfp_pkg::HASH_W-1:0]    out_hash
);

    localparam int HW = wfp_pkg::HASH_W;
    localparam int KAW = $clog2(MAX_KGRAM);
    localparam int KCW = $clog2(MAX_KGRAM + 1);
    localparam int WAW = $clog2(MAX_WINDOW);
    localparam int WCW = $clog2(MAX_WINDOW + 1);
    localparam logic [HW+1:0] MOD_X = {2'b00, wfp_pkg::HASH_MOD};
    localparam logic [HW+1:0] MOD2_X = {1'b0, wfp_pkg::HASH_MOD, 1'b0};
    localparam logic [HW+1:0] MOD3_X = MOD_X + MOD2_X;

    logic [6:0]    kgram_cfg_reg;
    logic [6:0]    window_cfg_reg;
    logic [HW-1:0] weight_cfg_reg;

    logic [7:0]     byte_reg;
    logic [KAW-1:0] byte_ptr_reg;
    logic [KCW-1:0] seen_reg;
    logic [HW-1:0]  hash_reg;
    logic [7:0]     oldest_reg;
    logic [HW-1:0]  acc_reg;
    logic [HW-1:0]  fix_reg;
    logic [WAW-1:0] hptr_reg;
    logic [WCW-1:0] hseen_reg;
    logic [HW-1:0]  min_reg;
    logic [WCW-1:0] age_reg;
    logic           rescan_reg;
    logic           emit_reg;
    logic [WCW-1:0] issue_left_reg;
    logic [WAW-1:0] issue_back_reg;
    logic           cmp_valid_reg;
    logic [WAW-1:0] cmp_back_reg;
    logic           first_reg;
    logic [HW-1:0]  out_reg;

    logic [KCW-1:0] k_eff;
    logic [WCW-1:0] w_eff;
    logic [HW-1:0]  tw_red;
    logic           kgram_full;

    logic [KAW+1:0] old_sum;
    logic [KAW+1:0] old_wrap;
    logic [KAW-1:0] old_addr;
    logic [7:0]     old_byte;

    logic [WAW:0]   scan_sum;
    logic [WAW:0]   scan_wrap;
    logic [WAW-1:0] scan_addr;
    logic           scan_re;
    logic [HW-1:0]  scan_data;

    logic [HW+1:0]  mul_sum;
    logic [HW-1:0]  acc_next;
    logic [HW-1:0]  fix_next;
    logic [HW-1:0]  hash_base;
    logic [HW+1:0]  hash_sum;
    logic [HW-1:0]  hash_next;

    always_comb begin
        if (kgram_cfg_reg == 7'd0) begin
            k_eff = KCW'(1);
        end else if (int'(kgram_cfg_reg) > MAX_KGRAM) begin
            k_eff = KCW'(MAX_KGRAM);
        end else begin
            k_eff = KCW'(kgram_cfg_reg);
        end
        if (window_cfg_reg == 7'd0) begin
            w_eff = WCW'(1);
        end else if (int'(window_cfg_reg) > MAX_WINDOW) begin
            w_eff = WCW'(MAX_WINDOW);
        end else begin
            w_eff = WCW'(window_cfg_reg);
        end
    end

    assign tw_red = (weight_cfg_reg >= wfp_pkg::HASH_MOD) ?
                    weight_cfg_reg - wfp_pkg::HASH_MOD : weight_cfg_reg;
    assign kgram_full = !(seen_reg < k_eff);

    // byte leaving the k-gram: k places behind the write pointer
    assign old_sum  = {2'b00, byte_ptr_reg} + (KAW+2)'(MAX_KGRAM) - (KAW+2)'(k_eff);
    assign old_wrap = (old_sum >= (KAW+2)'(MAX_KGRAM)) ? old_sum - (KAW+2)'(MAX_KGRAM)
                                                       : old_sum;
    assign old_addr = old_wrap[KAW-1:0];

    // window entry issue_back places behind the newest
    assign scan_sum  = {1'b0, hptr_reg} + (WAW+1)'(MAX_WINDOW - 1) - {1'b0, issue_back_reg};
    assign scan_wrap = (scan_sum >= (WAW+1)'(MAX_WINDOW)) ? scan_sum - (WAW+1)'(MAX_WINDOW)
                                                         : scan_sum;
    assign scan_addr = scan_wrap[WAW-1:0];
    assign scan_re   = cmd.scan_step && (issue_left_reg != '0);

    // one bit of oldest * weight, MSB first
    always_comb begin
        mul_sum = {1'b0, acc_reg, 1'b0} + (oldest_reg[7] ? {2'b00, tw_red} : '0);
        if (mul_sum >= MOD2_X) begin
            acc_next = HW'(mul_sum - MOD2_X);
        end else if (mul_sum >= MOD_X) begin
            acc_next = HW'(mul_sum - MOD_X);
        end else begin
            acc_next = HW'(mul_sum);
        end
    end

    assign fix_next = (hash_reg >= acc_reg) ? hash_reg - acc_reg
                                            : hash_reg + wfp_pkg::HASH_MOD - acc_reg;

    // 3 * base + byte can reach just past three moduli
    always_comb begin
        hash_base = kgram_full ? fix_reg : hash_reg;
        hash_sum  = {1'b0, hash_base, 1'b0} + {2'b00, hash_base} + {{(HW-6){1'b0}}, byte_reg};
        if (hash_sum >= MOD3_X) begin
            hash_next = HW'(hash_sum - MOD3_X);
        end else if (hash_sum >= MOD2_X) begin
            hash_next = HW'(hash_sum - MOD2_X);
        end else if (hash_sum >= MOD_X) begin
            hash_next = HW'(hash_sum - MOD_X);
        end else begin
            hash_next = HW'(hash_sum);
        end
    end

    wfp_ram #(.WIDTH(8), .DEPTH(MAX_KGRAM)) u_byte_ram (
        .aclk  (aclk),
        .we    (cmd.hash_upd),
        .waddr (byte_ptr_reg),
        .wdata (byte_reg),
        .re    (cmd.rd_oldest),
        .raddr (old_addr),
        .rdata (old_byte)
    );

    wfp_ram #(.WIDTH(HW), .DEPTH(MAX_WINDOW)) u_window_ram (
        .aclk  (aclk),
        .we    (cmd.win_upd),
        .waddr (hptr_reg),
        .wdata (hash_reg),
        .re    (scan_re),
        .raddr (scan_addr),
        .rdata (scan_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kgram_cfg_reg  <= wfp_pkg::KGRAM_RESET;
            window_cfg_reg <= wfp_pkg::WINDOW_RESET;
            weight_cfg_reg <= wfp_pkg::WEIGHT_RESET;
            byte_ptr_reg   <= '0;
            seen_reg       <= '0;
            hash_reg       <= '0;
            acc_reg        <= '0;
            hptr_reg       <= '0;
            hseen_reg      <= '0;
            min_reg        <= '0;
            age_reg        <= '0;
            rescan_reg     <= 1'b0;
            emit_reg       <= 1'b0;
            issue_left_reg <= '0;
            cmp_valid_reg  <= 1'b0;
            first_reg      <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    wfp_pkg::REG_KGRAM_LENGTH: kgram_cfg_reg  <= cfg_wr_data[6:0];
                    wfp_pkg::REG_WINDOW_WIDTH: window_cfg_reg <= cfg_wr_data[6:0];
                    wfp_pkg::REG_TOP_WEIGHT:   weight_cfg_reg <= cfg_wr_data[HW-1:0];
                    default: ;
                endcase
            end

            if (cmd.take) begin
                byte_reg <= s_byte_value;
                if (s_new_file) begin
                    byte_ptr_reg <= '0;
                    seen_reg     <= '0;
                    hash_reg     <= '0;
                    hptr_reg     <= '0;
                    hseen_reg    <= '0;
                    min_reg      <= '0;
                    age_reg      <= '0;
                end
            end

            if (cmd.mul_start) begin
                oldest_reg <= old_byte;
                acc_reg    <= '0;
            end
            if (cmd.mul_step) begin
                acc_reg    <= acc_next;
                oldest_reg <= {oldest_reg[6:0], 1'b0};
            end
            if (cmd.fix) begin
                fix_reg <= fix_next;
            end

            if (cmd.hash_upd) begin
                hash_reg     <= hash_next;
                byte_ptr_reg <= (byte_ptr_reg == KAW'(MAX_KGRAM - 1)) ? '0
                                                                      : byte_ptr_reg + 1'b1;
                if (!kgram_full) begin
                    seen_reg <= seen_reg + 1'b1;
                end
            end

            if (cmd.win_upd) begin
                hptr_reg   <= (hptr_reg == WAW'(MAX_WINDOW - 1)) ? '0 : hptr_reg + 1'b1;
                rescan_reg <= 1'b0;
                emit_reg   <= 1'b0;
                if (hseen_reg < w_eff) begin
                    hseen_reg  <= hseen_reg + 1'b1;
                    rescan_reg <= ({1'b0, hseen_reg} + 1'b1) >= {1'b0, w_eff};
                end else if (({1'b0, age_reg} + 1'b1) < {1'b0, w_eff}) begin
                    if (hash_reg <= min_reg) begin
                        min_reg  <= hash_reg;
                        age_reg  <= '0;
                        emit_reg <= 1'b1;
                    end else begin
                        age_reg <= age_reg + 1'b1;
                    end
                end else begin
                    rescan_reg <= 1'b1;
                end
            end

            if (cmd.scan_start) begin
                issue_left_reg <= w_eff;
                issue_back_reg <= WAW'(w_eff - 1'b1);
                first_reg      <= 1'b1;
                cmp_valid_reg  <= 1'b0;
            end
            if (cmd.scan_step) begin
                if (issue_left_reg != '0) begin
                    cmp_valid_reg  <= 1'b1;
                    cmp_back_reg   <= issue_back_reg;
                    issue_back_reg <= issue_back_reg - 1'b1;
                    issue_left_reg <= issue_left_reg - 1'b1;
                end else begin
                    cmp_valid_reg <= 1'b0;
                end
                // ties replace: the rightmost equal value wins
                if (cmp_valid_reg && (first_reg || scan_data <= min_reg)) begin
                    min_reg   <= scan_data;
                    age_reg   <= WCW'(cmp_back_reg);
                    first_reg <= 1'b0;
                end
            end

            if (cmd.out_load) begin
                out_reg <= min_reg;
            end
        end
    end

    assign sts.kgram_full = kgram_full;
    assign sts.rescan     = rescan_reg;
    assign sts.emit       = emit_reg;
    assign sts.scan_done  = (issue_left_reg == '0) && !cmp_valid_reg;
    assign sts.min_nz     = (min_reg != '0);
    assign out_hash       = out_reg;

    a_hash_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        hash_reg < wfp_pkg::HASH_MOD)
        else $error("running hash not reduced");

    a_acc_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mul_step |=> acc_reg < wfp_pkg::HASH_MOD)
        else $error("product accumulator not reduced");

    a_one_outcome: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.win_upd |=> !(rescan_reg && emit_reg))
        else $error("window update asked for both rescan and direct emit");

endmodule

>>> rtl/wfp_ctrl.sv
`timescale 1ns / 1ps

module wfp_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output wfp_pkg::wfp_cmd_t cmd,
    input  wfp_pkg::wfp_sts_t sts
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_CHK, ST_RD, ST_LATCH, ST_MUL, ST_FIX, ST_HASH, ST_WCHK,
        ST_WIN, ST_DEC, ST_SCAN0, ST_SCAN, ST_OUT
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] bit_cnt_reg;
    logic       m_valid_reg;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.take   = 1'b1;
                    state_next = ST_CHK;
                end
            end
            ST_CHK:   state_next = sts.kgram_full ? ST_RD : ST_HASH;
            ST_RD: begin
                cmd.rd_oldest = 1'b1;
                state_next    = ST_LATCH;
            end
            ST_LATCH: begin
                cmd.mul_start = 1'b1;
                state_next    = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul_step = 1'b1;
                if (bit_cnt_reg == 3'd7) begin
                    state_next = ST_FIX;
                end
            end
            ST_FIX: begin
                cmd.fix    = 1'b1;
                state_next = ST_HASH;
            end
            ST_HASH: begin
                cmd.hash_upd = 1'b1;
                state_next   = ST_WCHK;
            end
            ST_WCHK:  state_next = sts.kgram_full ? ST_WIN : ST_IDLE;
            ST_WIN: begin
                cmd.win_upd = 1'b1;
                state_next  = ST_DEC;
            end
            ST_DEC: begin
                priority if (sts.rescan) begin
                    state_next = ST_SCAN0;
                end else if (sts.emit) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN0: begin
                cmd.scan_start = 1'b1;
                state_next     = ST_SCAN;
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (sts.scan_done) begin
                    cmd.scan_step = 1'b0;
                    state_next    = ST_OUT;
                end
            end
            ST_OUT: begin
                priority if (!sts.min_nz) begin
                    state_next = ST_IDLE;
                end else if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            bit_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cmd.mul_step) begin
                bit_cnt_reg <= bit_cnt_reg + 1'b1;
            end else begin
                bit_cnt_reg <= '0;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

>>> sim/tb_winnowing_fingerprint.sv
`timescale 1ns / 1ps

module tb_winnowing_fingerprint;

    localparam longint unsigned MOD_TEN = 64'd10000000000;
    localparam int SLOTS = 64;
    localparam int SETTLE_CYCLES = 120;
    localparam longint unsigned CYCLE_LIMIT = 1000000;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           cfg_wr_en = 1'b0;
    logic [wfp_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [wfp_pkg::CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    logic [7:0]                     s_byte_value = '0;
    logic                           s_new_file = 1'b0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic [wfp_pkg::HASH_W-1:0]     m_fingerprint_hash;

    winnowing_fingerprint dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_byte_value(s_byte_value), .s_new_file(s_new_file),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_fingerprint_hash(m_fingerprint_hash)
    );

    always #10 aclk = ~aclk;

    // Shadow of the block: configuration plus hashing and window state.
    logic [6:0]      kgram_reg, window_reg;
    logic [33:0]     weight_reg;
    logic [7:0]      byte_ring [SLOTS];
    longint unsigned hash_ring [SLOTS];
    longint unsigned roll_hash, held_min, min_age;
    int              byte_cnt, hash_cnt, byte_wp, hash_wp;

    longint unsigned fingerprint_q[$];
    int              errors = 0;
    bit              sink_steady = 1'b0;
    bit              source_steady = 1'b0;
    longint unsigned cycles = 0;

    function automatic int clamp_size(logic [6:0] v);
        if (v == 0) return 1;
        if (v > SLOTS) return SLOTS;
        return int'(v);
    endfunction

    function automatic void clear_history();
        for (int i = 0; i < SLOTS; i++) begin
            byte_ring[i] = '0;
            hash_ring[i] = 0;
        end
        roll_hash = 0; held_min = 0; min_age = 0;
        byte_cnt = 0; hash_cnt = 0; byte_wp = 0; hash_wp = 0;
    endfunction

    // Rightmost minimum over the newest w hashes.
    function automatic void rescan_window(int w);
        longint unsigned v;
        int back;
        for (back = w - 1; back >= 0; back--) begin
            v = hash_ring[(hash_wp + SLOTS - 1 - back) % SLOTS];
            if (back == w - 1 || v <= held_min) begin
                held_min = v;
                min_age = back;
            end
        end
    endfunction

    // Advance the shadow by one byte; return 1 with the fingerprint if one leaves.
    function automatic bit winnow_byte(logic [7:0] b, logic nf,
                                       output longint unsigned fp);
        int k, w;
        longint unsigned leaving, sub, fixed;
        bit fire;
        k = clamp_size(kgram_reg);
        w = clamp_size(window_reg);
        fire = 1'b0;
        fp = 0;
        if (nf) clear_history();
        if (byte_cnt < k) begin
            roll_hash = (roll_hash * 3 + b) % MOD_TEN;
            byte_cnt++;
        end else begin
            leaving = byte_ring[(byte_wp + SLOTS - k) % SLOTS];
            sub = (leaving * (longint'(weight_reg) % MOD_TEN)) % MOD_TEN;
            fixed = (roll_hash + MOD_TEN - sub) % MOD_TEN;
            roll_hash = (fixed * 3 + b) % MOD_TEN;
        end
        byte_ring[byte_wp] = b;
        byte_wp = (byte_wp + 1) % SLOTS;
        if (byte_cnt < k) return 1'b0;
        hash_ring[hash_wp] = roll_hash;
        hash_wp = (hash_wp + 1) % SLOTS;
        if (hash_cnt < w) begin
            hash_cnt++;
            if (hash_cnt < w) return 1'b0;
            rescan_window(w);
            fire = 1'b1;
        end else if (min_age + 1 <= w - 1) begin
            if (roll_hash <= held_min) begin
                held_min = roll_hash;
                min_age = 0;
                fire = 1'b1;
            end else begin
                min_age++;
            end
        end else begin
            rescan_window(w);
            fire = 1'b1;
        end
        fp = held_min;
        return fire && held_min != 0;
    endfunction

    function automatic longint unsigned pow3_weight(int k);
        longint unsigned p;
        p = 1;
        for (int i = 1; i < k; i++) p = (p * 3) % MOD_TEN;
        return p;
    endfunction

    // Timeout watchdog.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Result side: compare each accepted word, then draw the next stall.
    int stall_left = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (fingerprint_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected word, expected none actual %0d",
                             $time, m_fingerprint_hash);
                end else begin
                    if (longint'(m_fingerprint_hash) != fingerprint_q[0]) begin
                        errors++;
                        $display("%0t: fingerprint_hash expected %0d actual %0d",
                                 $time, fingerprint_q[0], m_fingerprint_hash);
                    end
                    void'(fingerprint_q.pop_front());
                end
                stall_left = sink_steady ? 0 : $urandom_range(0, 15);
                m_ready <= (stall_left == 0);
            end else if (!m_ready) begin
                if (stall_left > 0) stall_left--;
                if (stall_left == 0) m_ready <= 1'b1;
            end
        end
    end

    // Drive one word, optionally with a typed expectation instead of the shadow's.
    task automatic send_byte(logic [7:0] b, logic nf, bit typed, longint unsigned typed_fp);
        int gap;
        longint unsigned fp;
        bit fire;
        gap = source_steady ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_byte_value <= b;
        s_new_file <= nf;
        do @(posedge aclk); while (!s_ready);
        fire = winnow_byte(b, nf, fp);
        if (typed) begin
            if (typed_fp != 0) fingerprint_q = {fingerprint_q, typed_fp};
        end else if (fire) begin
            fingerprint_q = {fingerprint_q, fp};
        end
    endtask

    // Hold until the result queue drains, then let the block settle.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (fingerprint_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_config(logic [6:0] k, logic [6:0] w, logic [33:0] tw);
        cfg_wr_en <= 1'b1; cfg_index <= wfp_pkg::REG_KGRAM_LENGTH;
        cfg_wr_data <= wfp_pkg::CFG_DATA_W'(k);
        @(posedge aclk);
        cfg_wr_en <= 1'b1; cfg_index <= wfp_pkg::REG_WINDOW_WIDTH;
        cfg_wr_data <= wfp_pkg::CFG_DATA_W'(w);
        @(posedge aclk);
        cfg_wr_en <= 1'b1; cfg_index <= wfp_pkg::REG_TOP_WEIGHT; cfg_wr_data <= tw;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        kgram_reg = k; window_reg = w; weight_reg = tw;
    endtask

    // Random file content: low values provoke ties and zero hashes.
    task automatic random_phase(int count);
        logic [7:0] b;
        logic nf;
        int mode;
        for (int i = 0; i < count; i++) begin
            mode = $urandom_range(0, 9);
            if (mode < 3) b = 8'($urandom_range(0, 2));
            else if (mode == 3) b = 8'd0;
            else b = 8'($urandom_range(0, 255));
            nf = (i == 0) || ($urandom_range(0, 60) == 0);
            source_steady = ($urandom_range(0, 99) < 15);
            send_byte(b, nf, 1'b0, 0);
            if (i == count / 2 && $urandom_range(0, 3) == 0) drain_results();
        end
        source_steady = 1'b0;
    endtask

    typedef struct {
        logic [7:0]      b;
        logic            nf;
        bit              typed;
        longint unsigned fp;
    } stim_row_t;

    // With a 1-byte k-gram and a 1-hash window every nonzero byte is its own
    // fingerprint, so those rows carry typed expectations.
    stim_row_t unit_rows[] = '{
        '{8'd255, 1'b1, 1'b1, 255}, '{8'd0, 1'b0, 1'b1, 0}, '{8'd1, 1'b0, 1'b1, 1},
        '{8'd128, 1'b0, 1'b1, 128}, '{8'd127, 1'b1, 1'b1, 127}, '{8'd1, 1'b0, 1'b1, 1}
    };
    // Default k-gram and window: extremes, zero runs, and a mid-file restart.
    stim_row_t reset_rows[] = '{
        '{8'd255, 1'b1, 1'b0, 0}, '{8'd255, 1'b0, 1'b0, 0}, '{8'd255, 1'b0, 1'b0, 0},
        '{8'd255, 1'b0, 1'b0, 0}, '{8'd255, 1'b0, 1'b0, 0}, '{8'd0, 1'b0, 1'b0, 0},
        '{8'd0, 1'b0, 1'b0, 0}, '{8'd0, 1'b0, 1'b0, 0}, '{8'd1, 1'b0, 1'b0, 0},
        '{8'd1, 1'b0, 1'b0, 0}, '{8'd255, 1'b0, 1'b0, 0}, '{8'd0, 1'b0, 1'b0, 0},
        '{8'd3, 1'b1, 1'b0, 0}, '{8'd2, 1'b0, 1'b0, 0}, '{8'd1, 1'b0, 1'b0, 0},
        '{8'd0, 1'b0, 1'b0, 0}, '{8'd0, 1'b0, 1'b0, 0}, '{8'd0, 1'b0, 1'b0, 0},
        '{8'd0, 1'b0, 1'b0, 0}
    };

    initial begin
        logic [6:0] k, w;
        kgram_reg = wfp_pkg::KGRAM_RESET;
        window_reg = wfp_pkg::WINDOW_RESET;
        weight_reg = wfp_pkg::WEIGHT_RESET;
        clear_history();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        m_ready <= 1'b1;
        @(posedge aclk);

        // Reset configuration first, then the trivial one.
        foreach (reset_rows[i])
            send_byte(reset_rows[i].b, reset_rows[i].nf, reset_rows[i].typed, reset_rows[i].fp);
        drain_results();
        write_config(7'd1, 7'd1, 34'd1);
        foreach (unit_rows[i])
            send_byte(unit_rows[i].b, unit_rows[i].nf, unit_rows[i].typed, unit_rows[i].fp);
        drain_results();

        // Random phases over a spread of settings, extremes included.
        random_phase(60);
        drain_results();
        write_config(7'd64, 7'd64, 34'(pow3_weight(64)));
        random_phase(160);
        drain_results();
        write_config(7'd0, 7'd127, 34'h3FFFFFFFF);          // both lengths clamp
        random_phase(100);
        drain_results();
        write_config(7'd127, 7'd0, 34'(pow3_weight(64)));
        random_phase(80);
        drain_results();
        write_config(7'd5, 7'd4, 34'd81);
        sink_steady = 1'b1;
        random_phase(80);
        sink_steady = 1'b0;
        for (int p = 0; p < 6; p++) begin
            drain_results();
            k = 7'($urandom_range(1, 12));
            w = (p == 5) ? 7'd2 : 7'($urandom_range(1, 16));
            write_config(k, w, (p == 2) ? 34'($urandom) << 2 : 34'(pow3_weight(k)));
            random_phase(55);
        end

        drain_results();
        if (errors == 0 && fingerprint_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
